@@ src/rom_ram_bank_controller_assert.svh @@
// Assertion macros for the cartridge bank controller.
// No dependencies; the including file supplies clock and reset names.
`ifndef ROM_RAM_BANK_CONTROLLER_ASSERT_SVH
`define ROM_RAM_BANK_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RRBC_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`define RRBC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define RRBC_ASSERT_SAME(label, clk, rst, cond, expr)
`define RRBC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

@@ src/rrbc_pkg.sv @@
// Shared constants for the cartridge bank controller.
// No dependencies.
`default_nettype none
package rrbc_pkg;
   localparam int RAM_BYTES_DEFAULT = 32768;

   localparam int ADDR_W     = 16;
   localparam int ROM_ADDR_W = 21;
   localparam int SIZE_W     = 3;

   localparam logic [SIZE_W-1:0] SIZE_CODE_MAX   = 3'd6;
   localparam logic [SIZE_W-1:0] SIZE_CODE_RESET = 3'd6;

   // result target codes
   localparam logic [1:0] TARGET_ROM   = 2'd0;
   localparam logic [1:0] TARGET_RAM   = 2'd1;
   localparam logic [1:0] TARGET_OPEN  = 2'd2;
   localparam logic [1:0] TARGET_WRITE = 2'd3;

   // access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // address regions, by address[15:13]
   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_PRIMARY    = 3'd1;
   localparam logic [2:0] REGION_SECONDARY  = 3'd2;
   localparam logic [2:0] REGION_MODE       = 3'd3;
   localparam logic [2:0] REGION_SRAM       = 3'd5;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
endpackage
`default_nettype wire

@@ src/rom_ram_bank_controller.sv @@
// Cartridge bank controller top level: bank registers, ROM address mapping, save SRAM.
// Depends on rrbc_pkg and rom_ram_bank_controller_assert.svh.
//
// channel | direction | ports                                  | handshake
// req     | in        | req_kind, req_address, req_write_data  | req_valid / req_stall
// rsp     | out       | rsp_target, rsp_rom_address, rsp_read_data | rsp_valid / rsp_stall
// csr     | in        | csr_write_data (rom size code)         | csr_write_enable
//
// One item per cycle while req_stall is low; each result appears in the cycle after
// its item is taken, from the result register and the registered read port of the save SRAM.
// Reset puts the bank registers at their defaults (primary bank 1) and the size
// code at 6; the SRAM is not cleared and needs no sweep, so items are taken
// right after reset.
// rsp_stall holds the result register; req_stall rises only while a result is
// stalled, so a new item enters whenever the output register is free or drains.
`default_nettype none
`include "rom_ram_bank_controller_assert.svh"
module rom_ram_bank_controller #(
   parameter int RAM_BYTES = rrbc_pkg::RAM_BYTES_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_kind,
   input  wire  [rrbc_pkg::ADDR_W-1:0]          req_address,
   input  wire  [7:0]                           req_write_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [1:0]                           rsp_target,
   output logic [rrbc_pkg::ROM_ADDR_W-1:0]      rsp_rom_address,
   output logic [7:0]                           rsp_read_data,
   input  wire                                  csr_write_enable,
   input  wire  [rrbc_pkg::SIZE_W-1:0]          csr_write_data
);
   localparam int RamAw = $clog2(RAM_BYTES);
   localparam logic [16:0] Ram1 = 17'(RAM_BYTES);
   localparam logic [16:0] Ram2 = 17'(2 * RAM_BYTES);

   // control registers
   logic [2:0] size_code_ff, size_code_in;
   logic       ram_en_ff, ram_en_in;
   logic [4:0] primary_ff, primary_in;
   logic [1:0] secondary_ff, secondary_in;
   logic       ram_mode_ff, ram_mode_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [1:0]                         target_ff, target_in;
   logic [rrbc_pkg::ROM_ADDR_W-1:0]    rom_addr_ff, rom_addr_in;
   logic [7:0]                         rd_ff;

   logic [7:0] save_ram [RAM_BYTES];

   logic              accept;
   logic [2:0]        region;
   logic [2:0]        code_eff;
   logic [4:0]        primary_mask;
   logic [4:0]        primary_masked;
   logic [rrbc_pkg::ROM_ADDR_W-1:0] rom_mask;
   logic [rrbc_pkg::ROM_ADDR_W-1:0] rom_raw;
   logic [16:0]       ram_lin, ram_r1, ram_r2;
   logic [RamAw-1:0]  ram_index;
   logic              sram_hit;
   logic              sram_write;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign region    = req_address[15:13];

   // size codes above 6 act as 6
   assign code_eff = (size_code_ff > rrbc_pkg::SIZE_CODE_MAX) ? rrbc_pkg::SIZE_CODE_MAX
                                                               : size_code_ff;
   assign primary_mask = (code_eff >= 3'd4) ? 5'h1F : (5'h1F >> (3'd4 - code_eff));
   assign primary_masked = req_write_data[4:0] & primary_mask;
   // 32 KiB << code, minus one
   assign rom_mask = {rrbc_pkg::ROM_ADDR_W{1'b1}} >> (3'd6 - code_eff);

   // ROM map: bank 0 area follows the mode, switchable area always uses both banks
   always_comb begin
      if (!req_address[14]) begin
         rom_raw = ram_mode_ff ? {secondary_ff, 5'd0, req_address[13:0]}
                               : {7'd0, req_address[13:0]};
      end else begin
         rom_raw = {secondary_ff, primary_ff, req_address[13:0]};
      end
   end

   // SRAM index, reduced modulo RAM_BYTES (value < 4 * RAM_BYTES)
   assign ram_lin = ram_mode_ff ? {2'd0, secondary_ff, req_address[12:0]}
                                : {4'd0, req_address[12:0]};
   assign ram_r1 = (ram_lin >= Ram2) ? ram_lin - Ram2 : ram_lin;
   assign ram_r2 = (ram_r1 >= Ram1) ? ram_r1 - Ram1 : ram_r1;
   assign ram_index = ram_r2[RamAw-1:0];

   assign sram_hit   = (region == rrbc_pkg::REGION_SRAM) && ram_en_ff;
   assign sram_write = accept && (req_kind == rrbc_pkg::KIND_WRITE) && sram_hit;

   // next state of bank registers and result
   always_comb begin
      size_code_in = csr_write_enable ? csr_write_data : size_code_ff;
      ram_en_in    = ram_en_ff;
      primary_in   = primary_ff;
      secondary_in = secondary_ff;
      ram_mode_in  = ram_mode_ff;
      target_in    = target_ff;
      rom_addr_in  = rom_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rom_addr_in  = '0;
         if (req_kind == rrbc_pkg::KIND_WRITE) begin
            target_in = rrbc_pkg::TARGET_WRITE;
            priority if (region == rrbc_pkg::REGION_RAM_ENABLE) begin
               ram_en_in = (req_write_data[3:0] == rrbc_pkg::RAM_ENABLE_KEY);
            end else if (region == rrbc_pkg::REGION_PRIMARY) begin
               primary_in = (primary_masked == 5'd0) ? 5'd1 : primary_masked;
            end else if (region == rrbc_pkg::REGION_SECONDARY) begin
               secondary_in = req_write_data[1:0];
            end else if (region == rrbc_pkg::REGION_MODE) begin
               ram_mode_in = req_write_data[0];
            end else begin
               // SRAM write goes straight to the array; others ignored
               ram_en_in = ram_en_ff;
            end
         end else begin
            priority if (!req_address[15]) begin
               target_in   = rrbc_pkg::TARGET_ROM;
               rom_addr_in = rom_raw & rom_mask;
            end else if (sram_hit) begin
               target_in = rrbc_pkg::TARGET_RAM;
            end else begin
               target_in = rrbc_pkg::TARGET_OPEN;
            end
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_code_ff <= rrbc_pkg::SIZE_CODE_RESET;
         ram_en_ff    <= 1'b0;
         primary_ff   <= 5'd1;
         secondary_ff <= 2'd0;
         ram_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_code_ff <= size_code_in;
         ram_en_ff    <= ram_en_in;
         primary_ff   <= primary_in;
         secondary_ff <= secondary_in;
         ram_mode_ff  <= ram_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      rom_addr_ff <= rom_addr_in;
   end

   // save SRAM: write and read both happen at the accept edge, so a read that
   // follows a write to the same byte already sees the new value
   always_ff @(posedge clock) begin
      if (sram_write) begin
         save_ram[ram_index] <= req_write_data;
      end
      if (accept) begin
         rd_ff <= save_ram[ram_index];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target      = target_ff;
   assign rsp_rom_address = rom_addr_ff;
   assign rsp_read_data   = (target_ff == rrbc_pkg::TARGET_RAM) ? rd_ff : 8'd0;

   `RRBC_ASSERT_SAME(a_primary_nonzero, clock, reset, 1'b1, primary_ff != 5'd0)
   `RRBC_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)
   `RRBC_ASSERT_SAME(a_rom_addr_only_rom, clock, reset,
      rsp_valid_ff && (target_ff != rrbc_pkg::TARGET_ROM), rom_addr_ff == '0)
   `RRBC_ASSERT_NEXT(a_stall_holds_data, clock, reset, rsp_valid_ff && rsp_stall,
      $stable(rsp_read_data) && $stable(target_ff))
endmodule
`default_nettype wire

@@ tb/rom_ram_bank_controller_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for rom_ram_bank_controller: directed table, then random bus traffic.
// Depends on rrbc_pkg and the controller RTL; checks typed rows against the table and predicts the rest in-bench.
module rom_ram_bank_controller_tb;
   localparam int SAVE_BYTES = rrbc_pkg::RAM_BYTES_DEFAULT;
   localparam int RUN_LIMIT  = 400000;     // cycles; slowest legal run is well under this
   localparam int PHASE_ITEMS = 234;
   localparam bit TYPED   = 1'b1;
   localparam bit PREDICT = 1'b0;
   // size codes per random phase: extremes first, 7 must alias to 6
   localparam logic [rrbc_pkg::SIZE_W-1:0] PHASE_CODES [8] =
      '{3'd0, 3'd7, 3'd3, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6};

   typedef struct packed {
      logic [1:0]                      target;
      logic [rrbc_pkg::ROM_ADDR_W-1:0] rom_address;
      logic [7:0]                      read_data;
   } bus_result_type;

   typedef struct {
      logic            kind;
      logic [15:0]     address;
      logic [7:0]      write_data;
      bit              typed;
      bus_result_type  result;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_kind;
   logic [rrbc_pkg::ADDR_W-1:0]     req_address;
   logic [7:0]                      req_write_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [1:0]                      rsp_target;
   logic [rrbc_pkg::ROM_ADDR_W-1:0] rsp_rom_address;
   logic [7:0]                      rsp_read_data;
   logic                            csr_write_enable;
   logic [rrbc_pkg::SIZE_W-1:0]     csr_write_data;

   // predictor copy of the cartridge state
   logic [rrbc_pkg::SIZE_W-1:0] size_code_q = rrbc_pkg::SIZE_CODE_RESET;
   logic              ram_on      = 1'b0;
   logic [4:0]        primary_q   = 5'd1;
   logic [1:0]        secondary_q = 2'd0;
   logic              ram_mode_q  = 1'b0;
   logic [7:0]        save_bytes   [0:SAVE_BYTES-1];
   bit                save_written [0:SAVE_BYTES-1];

   bus_result_type results_due [$];
   stim_row_type   directed_rows [$];
   int          errors = 0;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b1;   // random gaps on both channels
   int          stall_hold = 0;

   rom_ram_bank_controller dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target       (rsp_target),
      .rsp_rom_address  (rsp_rom_address),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned eff_size();
      return (size_code_q > rrbc_pkg::SIZE_CODE_MAX) ? int'(rrbc_pkg::SIZE_CODE_MAX)
                                                     : int'(size_code_q);
   endfunction

   // physical address wraps to the current ROM size (32 KiB << code)
   function automatic logic [rrbc_pkg::ROM_ADDR_W-1:0] rom_wrap(input int unsigned a);
      int unsigned span;
      span = 32'h8000 << eff_size();
      return rrbc_pkg::ROM_ADDR_W'(a & (span - 1));
   endfunction

   // RAM mode adds the secondary bank on top of the 8 KiB window
   function automatic int sram_index(input logic [15:0] addr);
      int idx;
      idx = ram_mode_q ? int'({secondary_q, addr[12:0]}) : int'(addr[12:0]);
      return idx % SAVE_BYTES;
   endfunction

   function automatic bus_result_type bank_access(input logic kind,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] wdata);
      bus_result_type r;
      logic [4:0]  pmask;
      logic [4:0]  p;
      int unsigned base;
      r = '{rrbc_pkg::TARGET_OPEN, '0, 8'h00};
      pmask = (eff_size() >= 4) ? 5'h1F : (5'h1F >> (4 - eff_size()));
      if (kind == rrbc_pkg::KIND_WRITE) begin
         r.target = rrbc_pkg::TARGET_WRITE;
         unique case (addr[15:13])
            rrbc_pkg::REGION_RAM_ENABLE: ram_on = (wdata[3:0] == rrbc_pkg::RAM_ENABLE_KEY);
            rrbc_pkg::REGION_PRIMARY: begin
               // mask is fixed at write time; zero maps to bank 1
               p = wdata[4:0] & pmask;
               primary_q = (p == 5'd0) ? 5'd1 : p;
            end
            rrbc_pkg::REGION_SECONDARY: secondary_q = wdata[1:0];
            rrbc_pkg::REGION_MODE:      ram_mode_q = wdata[0];
            rrbc_pkg::REGION_SRAM: begin
               if (ram_on) begin
                  save_bytes[sram_index(addr)]   = wdata;
                  save_written[sram_index(addr)] = 1'b1;
               end
            end
            default: ;
         endcase
      end else if (addr[15] == 1'b0) begin
         r.target = rrbc_pkg::TARGET_ROM;
         if (addr[14] == 1'b0) begin
            // bank 0 area follows the secondary bank only in RAM mode
            base = ram_mode_q ? (int'(secondary_q) << 19) : 0;
            r.rom_address = rom_wrap(base + int'(addr));
         end else begin
            base = int'({secondary_q, primary_q}) * 32'h4000;
            r.rom_address = rom_wrap(base + int'(addr[13:0]));
         end
      end else if (addr[15:13] == rrbc_pkg::REGION_SRAM && ram_on) begin
         r.target    = rrbc_pkg::TARGET_RAM;
         r.read_data = save_bytes[sram_index(addr)];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic add_row(input logic kind, input logic [15:0] a, input logic [7:0] d,
                          input bit typed, input logic [1:0] t,
                          input logic [rrbc_pkg::ROM_ADDR_W-1:0] ra, input logic [7:0] rd);
      stim_row_type row;
      row.kind = kind;
      row.address = a;
      row.write_data = d;
      row.typed = typed;
      row.result = '{t, ra, rd};
      directed_rows.push_back(row);
   endtask

   // one item; the expectation is queued once the item is taken
   task automatic send_access(input logic kind, input logic [15:0] addr,
                              input logic [7:0] data, input bit typed,
                              input bus_result_type typed_result);
      bus_result_type predicted;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_address    <= addr;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = bank_access(kind, addr, data);
      results_due.push_back(typed ? typed_result : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   // size code only changes with the controller idle
   task automatic set_rom_size(input logic [rrbc_pkg::SIZE_W-1:0] code);
      csr_write_data   <= code;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      size_code_q = code;
   endtask

   // Mostly well-formed traffic: bank register writes, ROM reads, SRAM traffic
   // on a small set of offsets so reads hit written bytes; the rest is noise.
   task automatic random_access(output logic kind, output logic [15:0] addr,
                                output logic [7:0] data);
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      kind = 1'($urandom_range(0, 1));
      addr = 16'($urandom());
      data = 8'($urandom());
      if (pick < 16) begin
         kind = rrbc_pkg::KIND_WRITE;
         addr[15:13] = 3'($urandom_range(0, 3));
         // keep the RAM enabled most of the time
         if (addr[15:13] == rrbc_pkg::REGION_RAM_ENABLE && $urandom_range(0, 3) != 0)
            data[3:0] = rrbc_pkg::RAM_ENABLE_KEY;
      end else if (pick < 40) begin
         kind = rrbc_pkg::KIND_READ;
         addr[15] = 1'b0;
      end else if (pick < 78) begin
         addr[15:13] = rrbc_pkg::REGION_SRAM;
         sel = $urandom_range(0, 4);
         if (sel < 3)
            addr[12:0] = 13'($urandom_range(0, 31));
         else if (sel == 3)
            addr[12:0] = 13'h1FE0 + 13'($urandom_range(0, 31));
      end else if (pick < 88) begin
         addr = $urandom_range(0, 1) ? {3'b100, addr[12:0]}
                                     : 16'hC000 + 16'($urandom_range(0, 16'h3FFF));
      end
      // never read a save byte that was never written
      if (kind == rrbc_pkg::KIND_READ && addr[15:13] == rrbc_pkg::REGION_SRAM && ram_on &&
          !save_written[sram_index(addr)])
         kind = rrbc_pkg::KIND_WRITE;
   endtask

   // ---------------------------------------------------------------- result side
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_hold != 0) begin
            stall_hold--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_hold = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      bus_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result, target %0d rom_address %h read_data %h",
                     $time, rsp_target, rsp_rom_address, rsp_read_data);
            errors++;
         end else begin
            want = results_due.pop_front();
            if (rsp_target !== want.target) begin
               $display("%0t: target mismatch, expected %0d actual %0d",
                        $time, want.target, rsp_target);
               errors++;
            end
            if (rsp_rom_address !== want.rom_address) begin
               $display("%0t: rom_address mismatch, expected %h actual %h",
                        $time, want.rom_address, rsp_rom_address);
               errors++;
            end
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data mismatch, expected %h actual %h",
                        $time, want.read_data, rsp_read_data);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("rom_ram_bank_controller_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main flow
   initial begin
      logic        kind;
      logic [15:0] addr;
      logic [7:0]  data;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = rrbc_pkg::KIND_READ;
      req_address      = '0;
      req_write_data   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = rrbc_pkg::SIZE_CODE_RESET;

      // Directed table, reset state: size code 6, RAM off, primary 1.
      add_row(rrbc_pkg::KIND_READ,  16'h0000, 8'h00, TYPED, rrbc_pkg::TARGET_ROM,
              21'h000000, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'h3FFF, 8'h00, TYPED, rrbc_pkg::TARGET_ROM,
              21'h003FFF, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'h4000, 8'h00, TYPED, rrbc_pkg::TARGET_ROM,
              21'h004000, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'h7FFF, 8'h00, TYPED, rrbc_pkg::TARGET_ROM,
              21'h007FFF, 8'h00);
      // RAM disabled: open bus, write dropped
      add_row(rrbc_pkg::KIND_READ,  16'hA000, 8'h00, TYPED, rrbc_pkg::TARGET_OPEN, '0, 8'h00);
      add_row(rrbc_pkg::KIND_WRITE, 16'hA000, 8'hFF, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      // unmapped ranges
      add_row(rrbc_pkg::KIND_READ,  16'h8000, 8'h00, TYPED, rrbc_pkg::TARGET_OPEN, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'hFFFF, 8'h00, TYPED, rrbc_pkg::TARGET_OPEN, '0, 8'h00);
      add_row(rrbc_pkg::KIND_WRITE, 16'hC000, 8'h55, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      // enable key only looks at the low nibble
      add_row(rrbc_pkg::KIND_WRITE, 16'h0000, 8'hFA, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_WRITE, 16'hA000, 8'h00, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'hA000, 8'h00, TYPED, rrbc_pkg::TARGET_RAM, '0, 8'h00);
      add_row(rrbc_pkg::KIND_WRITE, 16'hBFFF, 8'hFF, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'hBFFF, 8'h00, TYPED, rrbc_pkg::TARGET_RAM, '0, 8'hFF);
      // primary bank of zero after masking becomes 1
      add_row(rrbc_pkg::KIND_WRITE, 16'h2000, 8'hE0, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'h4000, 8'h00, PREDICT, '0, '0, '0);
      add_row(rrbc_pkg::KIND_WRITE, 16'h3FFF, 8'hFF, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'h7FFF, 8'h00, PREDICT, '0, '0, '0);
      // secondary bank 3: switchable area uses it in both modes
      add_row(rrbc_pkg::KIND_WRITE, 16'h5FFF, 8'hFF, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'h4000, 8'h00, PREDICT, '0, '0, '0);
      add_row(rrbc_pkg::KIND_READ,  16'h0000, 8'h00, PREDICT, '0, '0, '0);
      // RAM mode: bank 0 area and SRAM both move with the secondary bank
      add_row(rrbc_pkg::KIND_WRITE, 16'h6000, 8'hFF, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'h0000, 8'h00, PREDICT, '0, '0, '0);
      add_row(rrbc_pkg::KIND_WRITE, 16'hB123, 8'h3C, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'hB123, 8'h00, PREDICT, '0, '0, '0);
      add_row(rrbc_pkg::KIND_WRITE, 16'h7FFF, 8'hFE, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      // disable again
      add_row(rrbc_pkg::KIND_WRITE, 16'h1FFF, 8'h0B, TYPED, rrbc_pkg::TARGET_WRITE, '0, 8'h00);
      add_row(rrbc_pkg::KIND_READ,  16'hBFFF, 8'h00, TYPED, rrbc_pkg::TARGET_OPEN, '0, 8'h00);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_access(directed_rows[i].kind, directed_rows[i].address,
                     directed_rows[i].write_data, directed_rows[i].typed,
                     directed_rows[i].result);

      // Random phases, one size code each; bank registers carry over so a
      // primary bank masked under one size is read back under another.
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         idle_on = (ph < 6) && (ph != 3);   // the tail runs at full rate
         set_rom_size(PHASE_CODES[ph]);
         repeat (PHASE_ITEMS) begin
            random_access(kind, addr, data);
            send_access(kind, addr, data, PREDICT, '0);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("rom_ram_bank_controller_tb passed");
      else
         $display("rom_ram_bank_controller_tb failed");
      $finish;
   end
endmodule
